FILE: src/pulse_width_capture_unit_macros.svh
`ifndef PULSE_WIDTH_CAPTURE_UNIT_MACROS_SVH
`define PULSE_WIDTH_CAPTURE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PWC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pulse width capture check failed");

// Next-cycle implication, checked outside reset.
`define PWC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pulse width capture check failed");

`endif

FILE: src/pwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwc_pkg;

	localparam int unsigned NUM_CHANNELS = 4;
	localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic [15:0] PERIOD_RESET = 16'd65535;
	localparam logic [15:0] MAXOV_RESET  = 16'd1000;
	localparam logic [3:0]  ENABLE_RESET = 4'hF;

	typedef enum logic [1:0] {
		CFG_PERIOD = 2'd0,
		CFG_MAXOV  = 2'd1,
		CFG_ENABLE = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_CAPTURE = 1'b1
	} op_t;

	typedef struct packed {
		logic        operation;
		logic [1:0]  chan_sel;
		logic [15:0] captured_count;
	} in_t;

	typedef struct packed {
		logic signed [32:0] pulse_width;
		logic [2:0]         channel_number;
	} out_t;

	typedef struct packed {
		logic [31:0] edge_overflow;
		logic [15:0] edge_count;
		logic        expect_falling;
	} ent_t;

endpackage

`default_nettype wire

FILE: src/pulse_width_capture_unit.sv
// Pulse width capture for up to four timer capture channels.
// Input channel (in_valid/in_ready/in_data): each beat is either an overflow
// tick, which advances the shared overflow count, or an edge capture on one
// channel carrying the latched counter value.
// Output channel (out_valid/out_ready/out_data): one beat per measured pulse,
// holding the signed width in counter ticks and the channel number from one.
// Ticks, captures on disabled channels and discarded pulses give no beat.
// Configuration: a write at cfg_we sets period, overflow limit or enables.
// Throughput is one input beat per cycle while the pipeline is not stalled.
// A capture passes through registered stages: the per-channel memory read,
// the difference stage, the 16x16 multiplier and the add and sign stage.
// Back-to-back captures on one channel are forwarded around the memory.
// Reset clears the overflow count and marks every channel entry as reset,
// so no clearing pass is needed and beats are accepted right away.
// When the receiver stalls, the result is held in the output register and
// the pipeline keeps accepting beats until all stages are full.
`timescale 1ns / 1ps
`default_nettype none

module pulse_width_capture_unit import pwc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_t         in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_t             out_data,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	logic [15:0] period_q;
	logic [15:0] maxov_q;
	logic [3:0]  enable_q;
	logic [31:0] ovf_q;

	ent_t mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] vld_q;

	logic rdy_o, rdy3, rdy2, rdy1;
	logic in_acc, cap_en, rd_en, wr_en;
	logic [CH_W-1:0] rd_addr, wr_addr;
	ent_t wr_ent, cur;

	logic        v1_s1;
	logic [1:0]  ch_s1;
	logic [15:0] cnt_s1;
	logic [31:0] now_s1;
	ent_t        raw_s1, fwd_ent_s1;
	logic        fwd_s1, rdvld_s1;

	logic               keep1;
	logic [31:0]        ovd1;
	logic               v2_s2;
	logic [15:0]        ovd_s2;
	logic signed [16:0] diff_s2;
	logic               low_s2;
	logic [1:0]         ch_s2;

	logic [31:0]        prod;
	logic               v3_s3;
	logic [31:0]        prod_s3;
	logic signed [16:0] diff_s3;
	logic               low_s3;
	logic [1:0]         ch_s3;

	logic signed [32:0] sum3;
	logic               out_valid_q;
	out_t               out_q;

	assign rdy_o = !out_valid_q || out_ready;
	assign rdy3 = !v3_s3 || rdy_o;
	assign rdy2 = !v2_s2 || rdy3;
	assign rdy1 = !v1_s1 || rdy2;
	assign in_ready = rdy1;
	assign in_acc = in_valid && rdy1;

	assign cap_en = (in_data.operation == OP_CAPTURE)
		&& (32'(in_data.chan_sel) < NUM_CHANNELS)
		&& enable_q[in_data.chan_sel];
	assign rd_en = in_acc && cap_en;
	assign rd_addr = CH_W'(in_data.chan_sel);

	assign wr_en = v1_s1 && rdy2;
	assign wr_addr = CH_W'(ch_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			maxov_q <= MAXOV_RESET;
			enable_q <= ENABLE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PERIOD: period_q <= cfg_wdata;
				CFG_MAXOV:  maxov_q <= cfg_wdata;
				CFG_ENABLE: enable_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= '0;
		end else if (in_acc && in_data.operation == OP_TICK) begin
			ovf_q <= ovf_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_ent;
		end
		if (rd_en) begin
			raw_s1 <= mem[rd_addr];
			fwd_ent_s1 <= wr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			fwd_s1 <= 1'b0;
			rdvld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				fwd_s1 <= wr_en && (wr_addr == rd_addr);
				rdvld_s1 <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (rdy1) begin
			v1_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ch_s1 <= in_data.chan_sel;
			cnt_s1 <= in_data.captured_count;
			now_s1 <= ovf_q;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			cur = fwd_ent_s1;
		end else if (rdvld_s1) begin
			cur = raw_s1;
		end else begin
			cur = '0;
		end
		wr_ent.edge_overflow = now_s1;
		wr_ent.edge_count = cnt_s1;
		wr_ent.expect_falling = !cur.expect_falling;
		ovd1 = now_s1 - cur.edge_overflow;
		keep1 = (now_s1 >= cur.edge_overflow) && (ovd1 <= {16'd0, maxov_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (rdy2) begin
			v2_s2 <= v1_s1 && keep1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ovd_s2 <= ovd1[15:0];
			diff_s2 <= $signed({1'b0, cnt_s1}) - $signed({1'b0, cur.edge_count});
			low_s2 <= !cur.expect_falling;
			ch_s2 <= ch_s1;
		end
	end

	assign prod = {16'd0, ovd_s2} * {16'd0, period_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (rdy3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v2_s2) begin
			prod_s3 <= prod;
			diff_s3 <= diff_s2;
			low_s3 <= low_s2;
			ch_s3 <= ch_s2;
		end
	end

	assign sum3 = $signed({1'b0, prod_s3}) + 33'(diff_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_o) begin
			out_valid_q <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && v3_s3) begin
			out_q.pulse_width <= low_s3 ? -sum3 : sum3;
			out_q.channel_number <= 3'(ch_s3) + 3'd1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire

FILE: src/pwc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "pulse_width_capture_unit_macros.svh"

module pwc_checker import pwc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire out_t out_data
);

	localparam logic [2:0] CHAN_MAX = 3'(NUM_CHANNELS);
	localparam logic signed [32:0] WIDTH_MAX = 33'sd4294901760;

	`PWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`PWC_ASSERT_NOW(a_chan_range, out_valid, out_data.channel_number != 3'd0 && out_data.channel_number <= CHAN_MAX)
	`PWC_ASSERT_NOW(a_width_range, out_valid, out_data.pulse_width <= WIDTH_MAX && out_data.pulse_width >= -WIDTH_MAX)
	`PWC_ASSERT_NOW(a_ready_free, !out_valid, in_ready)

endmodule

bind pulse_width_capture_unit pwc_checker u_pwc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

`default_nettype wire

FILE: tb/sv/pulse_width_capture_unit_test.sv
`timescale 1ns / 1ps

class pulse_width_scoreboard;
	logic [15:0] period;
	logic [15:0] max_ov;
	logic [3:0] enable;
	logic [31:0] ov_count;
	logic [31:0] last_ov [pwc_pkg::NUM_CHANNELS];
	logic [15:0] stored_cnt [pwc_pkg::NUM_CHANNELS];
	bit falling_next [pwc_pkg::NUM_CHANNELS];
	pwc_pkg::out_t widths_due [$];
	int mismatches;

	function void clear_state();
		period = pwc_pkg::PERIOD_RESET;
		max_ov = pwc_pkg::MAXOV_RESET;
		enable = pwc_pkg::ENABLE_RESET;
		ov_count = '0;
		for (int i = 0; i < pwc_pkg::NUM_CHANNELS; i++) begin
			last_ov[i] = '0;
			stored_cnt[i] = '0;
			falling_next[i] = 1'b0;
		end
		widths_due.delete();
		mismatches = 0;
	endfunction

	function void set_settings(logic [15:0] p, logic [15:0] m, logic [3:0] e);
		period = p;
		max_ov = m;
		enable = e;
	endfunction

	function int widths_outstanding();
		return widths_due.size();
	endfunction

	function void note_event(pwc_pkg::in_t beat);
		int ch;
		bit low_pulse;
		logic [31:0] now_ov;
		logic [31:0] prev_ov;
		logic [31:0] ovd;
		logic [15:0] prev_cnt;
		longint ovd_l;
		longint period_l;
		longint cnt_l;
		longint prev_l;
		longint span;
		pwc_pkg::out_t expected;
		if (beat.operation == pwc_pkg::OP_TICK) begin
			ov_count = ov_count + 32'd1;
			return;
		end
		ch = beat.chan_sel;
		if (ch >= pwc_pkg::NUM_CHANNELS || !enable[ch])
			return;
		low_pulse = !falling_next[ch];
		falling_next[ch] = low_pulse;
		now_ov = ov_count;
		prev_ov = last_ov[ch];
		prev_cnt = stored_cnt[ch];
		last_ov[ch] = now_ov;
		stored_cnt[ch] = beat.captured_count;
		if (now_ov < prev_ov)
			return;
		ovd = now_ov - prev_ov;
		if (ovd > {16'd0, max_ov})
			return;
		ovd_l = ovd;
		period_l = period;
		cnt_l = beat.captured_count;
		prev_l = prev_cnt;
		span = ovd_l * period_l + cnt_l - prev_l;
		if (low_pulse)
			span = -span;
		expected.pulse_width = span[32:0];
		expected.channel_number = 3'(ch + 1);
		widths_due.push_back(expected);
	endfunction

	function void check_pulse(pwc_pkg::out_t got);
		pwc_pkg::out_t expected;
		if (widths_due.size() == 0) begin
			$error("unexpected result beat: pulse_width %0d channel_number %0d",
				got.pulse_width, got.channel_number);
			mismatches++;
			return;
		end
		expected = widths_due.pop_front();
		if (got.pulse_width !== expected.pulse_width) begin
			$error("pulse_width: expected %0d, actual %0d",
				expected.pulse_width, got.pulse_width);
			mismatches++;
		end
		if (got.channel_number !== expected.channel_number) begin
			$error("channel_number: expected %0d, actual %0d",
				expected.channel_number, got.channel_number);
			mismatches++;
		end
	endfunction
endclass

module pulse_width_capture_unit_test;
	import pwc_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_wdata;

	int send_idle;
	int recv_idle;
	pulse_width_scoreboard sb;

	pulse_width_capture_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_event(in_data);
			if (out_valid && out_ready)
				sb.check_pulse(out_data);
		end
	end

	function automatic in_t make_beat(op_t op, int ch, int cnt);
		in_t beat;
		beat.operation = op;
		beat.chan_sel = 2'(ch);
		beat.captured_count = 16'(cnt);
		return beat;
	endfunction

	task automatic set_idling(int mode);
		case (mode)
			0: begin
				send_idle = 20;
				recv_idle = 82;
			end
			1: begin
				send_idle = 82;
				recv_idle = 20;
			end
			default: begin
				send_idle = 0;
				recv_idle = 0;
			end
		endcase
	endtask

	task automatic send_item(in_t beat);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (sb.widths_outstanding() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic write_settings(logic [15:0] p, logic [15:0] m, logic [3:0] e);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PERIOD;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_index <= CFG_MAXOV;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_index <= CFG_ENABLE;
		cfg_wdata <= {12'd0, e};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_settings(p, m, e);
	endtask

	task automatic run_segment(logic [15:0] p, logic [15:0] m, logic [3:0] e,
			int mode, int n);
		int done;
		int r;
		int ch;
		int cnt;
		int burst;
		write_settings(p, m, e);
		set_idling(mode);
		done = 0;
		while (done < n) begin
			r = $urandom_range(0, 99);
			if (r < 4 && m <= 16) begin
				burst = $urandom_range(m, m + 2);
				repeat (burst) send_item(make_beat(OP_TICK, 0, $urandom_range(0, 65535)));
				done += burst;
			end else if (r < 28) begin
				send_item(make_beat(OP_TICK, $urandom_range(0, 3), $urandom_range(0, 65535)));
				done++;
			end else begin
				ch = $urandom_range(0, 3);
				r = $urandom_range(0, 99);
				if (r < 10)
					cnt = 0;
				else if (r < 20)
					cnt = 65535;
				else
					cnt = $urandom_range(0, 65535);
				send_item(make_beat(OP_CAPTURE, ch, cnt));
				done++;
			end
		end
		drain_results();
	endtask

	initial begin
		sb = new;
		sb.clear_state();
		set_idling(0);
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_PERIOD;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: first edges, counter extremes and a negative counter difference.
		send_item(make_beat(OP_CAPTURE, 0, 0));
		send_item(make_beat(OP_CAPTURE, 0, 65535));
		send_item(make_beat(OP_TICK, 0, 0));
		send_item(make_beat(OP_CAPTURE, 0, 0));
		send_item(make_beat(OP_CAPTURE, 1, 65535));
		send_item(make_beat(OP_CAPTURE, 1, 0));
		send_item(make_beat(OP_CAPTURE, 2, 12345));
		send_item(make_beat(OP_TICK, 3, 65535));
		send_item(make_beat(OP_TICK, 0, 0));
		send_item(make_beat(OP_CAPTURE, 2, 0));
		send_item(make_beat(OP_CAPTURE, 3, 65535));
		send_item(make_beat(OP_CAPTURE, 3, 65535));
		send_item(make_beat(OP_TICK, 0, 0));
		send_item(make_beat(OP_CAPTURE, 3, 0));
		send_item(make_beat(OP_CAPTURE, 2, 16'h8000));
		send_item(make_beat(OP_CAPTURE, 1, 16'h7FFF));
		send_item(make_beat(OP_TICK, 0, 0));
		send_item(make_beat(OP_CAPTURE, 0, 16'hAAAA));
		send_item(make_beat(OP_CAPTURE, 0, 16'h5555));
		send_item(make_beat(OP_CAPTURE, 3, 16'hFFFF));
		drain_results();

		run_segment(16'd65535, 16'd65535, 4'hF, 0, 320);
		run_segment(16'd1, 16'd0, 4'b0101, 0, 300);
		run_segment(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 12)),
			4'($urandom_range(1, 15)), 1, 320);
		run_segment(16'd0, 16'd3, 4'b1010, 1, 300);
		run_segment(16'($urandom_range(1, 65535)), 16'd2, 4'h0, 2, 60);
		run_segment(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 12)),
			4'hF, 2, 560);

		if (sb.widths_outstanding() != 0) begin
			$error("%0d expected results never arrived", sb.widths_outstanding());
			sb.mismatches++;
		end
		if (sb.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
